[sv/ltsm_pkg.sv]
// Shared types, sizes and float helpers for the linear term sort/merge block.
// No dependencies; the front, back, adder, top level and testbench import this package.
`timescale 1ns / 1ps

package ltsm_pkg;

  // Buffer capacity and derived index widths
  localparam int MAX_TERMS = 64;
  localparam int AW        = $clog2(MAX_TERMS);
  localparam int CW        = $clog2(MAX_TERMS + 1);

  // Fixed field widths
  localparam int VAR_W  = 20;
  localparam int COEF_W = 64;

  // Double-precision layout
  localparam int EXP_W  = 11;
  localparam int FRAC_W = 52;

  // Default NaN produced by an invalid add
  localparam logic [COEF_W-1:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

  typedef struct packed {
    logic [VAR_W-1:0]  var_index;
    logic [COEF_W-1:0] coef_bits;
    logic              last_input;
  } in_item_t;

  typedef struct packed {
    logic [VAR_W-1:0]  out_var;
    logic [COEF_W-1:0] out_coef_bits;
    logic              last_output;
    logic              none_left;
    logic              was_rebuilt;
    logic              overflowed;
  } out_item_t;

  // One stored term
  typedef struct packed {
    logic [VAR_W-1:0]  var_index;
    logic [COEF_W-1:0] coef;
  } term_t;

  // Closed set handed from front to back
  typedef struct packed {
    logic [CW-1:0] count;
    logic          ovf;
  } job_t;

  function automatic logic coef_is_nan(input logic [COEF_W-1:0] c);
    coef_is_nan = (&c[62:52]) && (|c[51:0]);
  endfunction

  function automatic logic [COEF_W-1:0] coef_quiet(input logic [COEF_W-1:0] c);
    coef_quiet = coef_is_nan(c) ? (c | 64'h0008_0000_0000_0000) : c;
  endfunction

  function automatic logic coef_nonzero(input logic [COEF_W-1:0] c);
    coef_nonzero = |c[62:0];
  endfunction

endpackage

[sv/ltsm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ltsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/ltsm_fadd.sv]
// Multi-cycle IEEE 754 double adder, round to nearest even, one-bit normalize steps.
// Depends on ltsm_pkg.
`timescale 1ns / 1ps

module ltsm_fadd import ltsm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [COEF_W-1:0] a_i,
  input  logic [COEF_W-1:0] b_i,
  output logic              done_o,
  output logic [COEF_W-1:0] sum_o
);

  typedef enum logic [2:0] {
    FA_IDLE, FA_ALIGN, FA_ADD, FA_NORM, FA_ROUND, FA_DONE
  } fa_state_e;

  fa_state_e         state_q;
  logic [COEF_W-1:0] a_q, b_q, res_q;
  logic [55:0]       big_q, sml_q;
  logic [56:0]       s_q;
  logic [11:0]       exp_q;
  logic              sign_q, sub_q, zsign_q;

  // Alignment datapath
  logic              a_big, a_inf, b_inf;
  logic [COEF_W-1:0] x, y;
  logic [55:0]       mx, my, y_sh, y_mask;
  logic [11:0]       ex, ey;
  logic [10:0]       d;
  logic              y_sticky;

  always_comb begin
    a_big  = a_q[62:0] >= b_q[62:0];
    x      = a_big ? a_q : b_q;
    y      = a_big ? b_q : a_q;
    a_inf  = (&a_q[62:52]) && !(|a_q[51:0]);
    b_inf  = (&b_q[62:52]) && !(|b_q[51:0]);
    mx     = {(|x[62:52]), x[51:0], 3'b000};
    my     = {(|y[62:52]), y[51:0], 3'b000};
    ex     = (|x[62:52]) ? {1'b0, x[62:52]} : 12'd1;
    ey     = (|y[62:52]) ? {1'b0, y[62:52]} : 12'd1;
    d      = 11'(ex - ey);
    if (d >= 11'd56) begin
      y_sh     = '0;
      y_sticky = |my;
      y_mask   = '0;
    end else begin
      y_sh     = my >> d;
      y_mask   = (56'd1 << d) - 56'd1;
      y_sticky = |(my & y_mask);
    end
  end

  // Rounding datapath
  logic [EXP_W-1:0] e_field;
  logic [62:0]      mag;
  logic             up;

  always_comb begin
    e_field = s_q[55] ? exp_q[EXP_W-1:0] : '0;
    up      = s_q[2] && ((|s_q[1:0]) || s_q[3]);
    mag     = {e_field, s_q[54:3]} + 63'(up);
  end

  assign done_o = (state_q == FA_DONE);
  assign sum_o  = res_q;

  // Sequence the add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FA_IDLE;
    end else begin
      case (state_q)
        FA_IDLE: begin
          if (start_i) begin
            a_q     <= a_i;
            b_q     <= b_i;
            state_q <= FA_ALIGN;
          end
        end
        FA_ALIGN: begin
          zsign_q <= a_q[63] & b_q[63];
          if (coef_is_nan(a_q)) begin
            res_q   <= coef_quiet(a_q);
            state_q <= FA_DONE;
          end else if (coef_is_nan(b_q)) begin
            res_q   <= coef_quiet(b_q);
            state_q <= FA_DONE;
          end else if (a_inf && b_inf && (a_q[63] != b_q[63])) begin
            res_q   <= DEFAULT_NAN;
            state_q <= FA_DONE;
          end else if (a_inf) begin
            res_q   <= a_q;
            state_q <= FA_DONE;
          end else if (b_inf) begin
            res_q   <= b_q;
            state_q <= FA_DONE;
          end else begin
            big_q   <= mx;
            sml_q   <= {y_sh[55:1], y_sh[0] | y_sticky};
            exp_q   <= ex;
            sign_q  <= x[63];
            sub_q   <= a_q[63] ^ b_q[63];
            state_q <= FA_ADD;
          end
        end
        FA_ADD: begin
          s_q     <= sub_q ? ({1'b0, big_q} - {1'b0, sml_q})
                           : ({1'b0, big_q} + {1'b0, sml_q});
          state_q <= FA_NORM;
        end
        FA_NORM: begin
          if (s_q[56]) begin
            s_q     <= {1'b0, s_q[56:2], s_q[1] | s_q[0]};
            exp_q   <= exp_q + 12'd1;
            state_q <= FA_ROUND;
          end else if (!s_q[55] && (s_q != '0) && (exp_q > 12'd1)) begin
            s_q   <= {s_q[55:0], 1'b0};
            exp_q <= exp_q - 12'd1;
          end else begin
            state_q <= FA_ROUND;
          end
        end
        FA_ROUND: begin
          if (exp_q >= 12'd2047) begin
            res_q <= {sign_q, 11'h7FF, 52'd0};
          end else if (s_q == '0) begin
            res_q <= {zsign_q, 63'd0};
          end else begin
            res_q <= {sign_q, mag};
          end
          state_q <= FA_DONE;
        end
        FA_DONE: begin
          state_q <= FA_IDLE;
        end
        default: begin
          state_q <= FA_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/ltsm_front.sv]
// Front part: accepts terms, fills the raw term buffer, closes a set into the job slot.
// Depends on ltsm_pkg.
`timescale 1ns / 1ps

module ltsm_front import ltsm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  in_item_t      in_item_i,
  output logic          full_o,
  output logic          raw_we_o,
  output logic [AW-1:0] raw_waddr_o,
  output term_t         raw_wdata_o,
  output logic          job_valid_o,
  output job_t          job_o,
  input  logic          job_done_i
);

  logic [CW-1:0] cnt_q;
  logic          ovf_q;
  logic          job_valid_q;
  job_t          job_q;

  logic          accept;
  logic          has_room;
  logic [CW-1:0] cnt_next;
  logic          ovf_next;

  assign accept   = push_i && !job_valid_q;
  assign has_room = cnt_q < CW'(MAX_TERMS);
  assign cnt_next = has_room ? (cnt_q + CW'(1)) : cnt_q;
  assign ovf_next = ovf_q || !has_room;

  // Store the term while there is room
  assign raw_we_o    = accept && has_room;
  assign raw_waddr_o = cnt_q[AW-1:0];
  assign raw_wdata_o = '{var_index: in_item_i.var_index, coef: in_item_i.coef_bits};

  assign full_o      = job_valid_q;
  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  // Count terms and hand a closed set to the back part
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      if (job_done_i) begin
        job_valid_q <= 1'b0;
      end
      if (accept) begin
        if (in_item_i.last_input) begin
          job_valid_q <= 1'b1;
          job_q       <= '{count: cnt_next, ovf: ovf_next};
          cnt_q       <= '0;
          ovf_q       <= 1'b0;
        end else begin
          cnt_q <= cnt_next;
          ovf_q <= ovf_next;
        end
      end
    end
  end

endmodule

[sv/ltsm_back.sv]
// Back part: sorted merge; if rebuilt, emits merged nonzero sums, else the raw terms.
// Depends on ltsm_pkg, ltsm_ram and ltsm_fadd.
`timescale 1ns / 1ps

module ltsm_back import ltsm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          always_rebuild_i,
  input  logic          job_valid_i,
  input  job_t          job_i,
  output logic          job_done_o,
  output logic [AW-1:0] raw_raddr_o,
  input  term_t         raw_rdata_i,
  input  logic          pop_i,
  output logic          empty_o,
  output out_item_t     result_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_RAW, S_RAW_GOT, S_SCAN, S_SCAN_GOT, S_SHIFT, S_SHIFT_GOT,
    S_ADD_WAIT, S_CMP_RD, S_CMP_GOT, S_EM_SET, S_EM_NONE, S_EM_RD, S_EM_GOT, S_FIN
  } bk_state_e;

  bk_state_e         state_q;
  logic [CW-1:0]     i_q, j_q, k_q, n_q, p_q, kept_q, e_q, total_q;
  logic [VAR_W-1:0]  v_q;
  logic [COEF_W-1:0] c_q;
  logic              changed_q, rebuilt_q;
  logic              out_valid_q;
  out_item_t         out_q;

  // Merged store
  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  term_t         m_wdata, m_rdata;

  // Adder
  logic              add_start, add_done;
  logic [COEF_W-1:0] add_sum;

  logic          hit_eq;
  logic [CW-1:0] k_dec;
  term_t         em_term;

  assign hit_eq   = (m_rdata.var_index == v_q);
  assign k_dec    = k_q - CW'(1);
  assign em_term  = rebuilt_q ? m_rdata : raw_rdata_i;
  assign add_start = (state_q == S_SCAN_GOT) && hit_eq;

  ltsm_ram #(
    .WIDTH($bits(term_t)),
    .DEPTH(MAX_TERMS)
  ) u_merged (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(m_wdata),
    .raddr_i(m_raddr),
    .rdata_o(m_rdata)
  );

  ltsm_fadd u_fadd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(add_start),
    .a_i    (m_rdata.coef),
    .b_i    (c_q),
    .done_o (add_done),
    .sum_o  (add_sum)
  );

  // Drive store addresses and writes from the current step
  always_comb begin
    m_we        = 1'b0;
    m_waddr     = j_q[AW-1:0];
    m_wdata     = '{var_index: v_q, coef: coef_quiet(c_q)};
    m_raddr     = j_q[AW-1:0];
    raw_raddr_o = i_q[AW-1:0];
    case (state_q)
      S_SCAN: begin
        m_raddr = j_q[AW-1:0];
      end
      S_SHIFT: begin
        m_raddr = k_dec[AW-1:0];
        m_we    = (k_q == j_q);
      end
      S_SHIFT_GOT: begin
        m_we    = 1'b1;
        m_waddr = k_q[AW-1:0];
        m_wdata = m_rdata;
      end
      S_ADD_WAIT: begin
        m_we    = add_done;
        m_wdata = '{var_index: v_q, coef: add_sum};
      end
      S_CMP_RD: begin
        m_raddr = p_q[AW-1:0];
      end
      S_CMP_GOT: begin
        m_we    = coef_nonzero(m_rdata.coef);
        m_waddr = kept_q[AW-1:0];
        m_wdata = m_rdata;
      end
      S_EM_RD: begin
        m_raddr     = e_q[AW-1:0];
        raw_raddr_o = e_q[AW-1:0];
      end
      default: begin
        m_we = 1'b0;
      end
    endcase
  end

  assign job_done_o = (state_q == S_FIN);
  assign empty_o    = !out_valid_q;
  assign result_o   = out_q;

  // Merge, compact and emit sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            i_q       <= '0;
            n_q       <= '0;
            changed_q <= 1'b0;
            state_q   <= S_RD_RAW;
          end
        end
        S_RD_RAW: begin
          if (i_q == job_i.count) begin
            rebuilt_q <= always_rebuild_i || changed_q;
            p_q       <= '0;
            kept_q    <= '0;
            state_q   <= (always_rebuild_i || changed_q) ? S_CMP_RD : S_EM_SET;
          end else begin
            state_q <= S_RAW_GOT;
          end
        end
        S_RAW_GOT: begin
          v_q <= raw_rdata_i.var_index;
          c_q <= raw_rdata_i.coef;
          if (!coef_nonzero(raw_rdata_i.coef)) begin
            changed_q <= 1'b1;
            i_q       <= i_q + CW'(1);
            state_q   <= S_RD_RAW;
          end else begin
            j_q     <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (j_q == n_q) begin
            k_q     <= n_q;
            state_q <= S_SHIFT;
          end else begin
            state_q <= S_SCAN_GOT;
          end
        end
        S_SCAN_GOT: begin
          if (m_rdata.var_index < v_q) begin
            j_q     <= j_q + CW'(1);
            state_q <= S_SCAN;
          end else if (hit_eq) begin
            changed_q <= 1'b1;
            state_q   <= S_ADD_WAIT;
          end else begin
            k_q     <= n_q;
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (k_q == j_q) begin
            n_q     <= n_q + CW'(1);
            i_q     <= i_q + CW'(1);
            state_q <= S_RD_RAW;
          end else begin
            state_q <= S_SHIFT_GOT;
          end
        end
        S_SHIFT_GOT: begin
          k_q     <= k_dec;
          state_q <= S_SHIFT;
        end
        S_ADD_WAIT: begin
          if (add_done) begin
            i_q     <= i_q + CW'(1);
            state_q <= S_RD_RAW;
          end
        end
        S_CMP_RD: begin
          state_q <= (p_q == n_q) ? S_EM_SET : S_CMP_GOT;
        end
        S_CMP_GOT: begin
          if (coef_nonzero(m_rdata.coef)) begin
            kept_q <= kept_q + CW'(1);
          end
          p_q     <= p_q + CW'(1);
          state_q <= S_CMP_RD;
        end
        S_EM_SET: begin
          e_q     <= '0;
          total_q <= rebuilt_q ? kept_q : job_i.count;
          state_q <= ((rebuilt_q ? kept_q : job_i.count) == '0) ? S_EM_NONE : S_EM_RD;
        end
        S_EM_NONE: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_q       <= '{out_var: '0, out_coef_bits: '0, last_output: 1'b1,
                             none_left: 1'b1, was_rebuilt: rebuilt_q,
                             overflowed: job_i.ovf};
            state_q     <= S_FIN;
          end
        end
        S_EM_RD: begin
          if (!out_valid_q) begin
            state_q <= S_EM_GOT;
          end
        end
        S_EM_GOT: begin
          out_valid_q <= 1'b1;
          out_q       <= '{out_var: em_term.var_index, out_coef_bits: em_term.coef,
                           last_output: (e_q + CW'(1) == total_q), none_left: 1'b0,
                           was_rebuilt: rebuilt_q, overflowed: job_i.ovf};
          e_q         <= e_q + CW'(1);
          state_q     <= (e_q + CW'(1) == total_q) ? S_FIN : S_EM_RD;
        end
        S_FIN: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/linear_term_sort_merge.sv]
// Terms load at one per cycle while full is low; after the closing term the merge scans
// the merged store, shifts entries up to insert and runs the adder on each duplicate;
// results then leave one at a time, each read only once the last has been popped.
// One set is in flight at a time: full stays high from the closing term until it ends.
// Reset is asynchronous and clears all control state; no memory clearing pass is run.
`timescale 1ns / 1ps

module linear_term_sort_merge import ltsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t result_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  logic          always_rebuild_q;
  logic          raw_we;
  logic [AW-1:0] raw_waddr, raw_raddr;
  term_t         raw_wdata, raw_rdata;
  logic          job_valid, job_done;
  job_t          job;

  // Hold the configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      always_rebuild_q <= 1'b0;
    end else if (cfg_valid_i) begin
      always_rebuild_q <= cfg_data_i;
    end
  end

  ltsm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .full_o     (full),
    .raw_we_o   (raw_we),
    .raw_waddr_o(raw_waddr),
    .raw_wdata_o(raw_wdata),
    .job_valid_o(job_valid),
    .job_o      (job),
    .job_done_i (job_done)
  );

  ltsm_ram #(
    .WIDTH($bits(term_t)),
    .DEPTH(MAX_TERMS)
  ) u_raw (
    .clk_i  (clk_i),
    .we_i   (raw_we),
    .waddr_i(raw_waddr),
    .wdata_i(raw_wdata),
    .raddr_i(raw_raddr),
    .rdata_o(raw_rdata)
  );

  ltsm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .always_rebuild_i(always_rebuild_q),
    .job_valid_i     (job_valid),
    .job_i           (job),
    .job_done_o      (job_done),
    .raw_raddr_o     (raw_raddr),
    .raw_rdata_i     (raw_rdata),
    .pop_i           (pop),
    .empty_o         (empty),
    .result_o        (result_o)
  );

endmodule

[test/linear_term_sort_merge_tb.sv]
// Self-checking testbench for linear_term_sort_merge: directed and random term sets,
// a scoreboard predicting sorted merged or raw output. Uses ltsm_pkg and the DUT.
`timescale 1ns / 1ps

module linear_term_sort_merge_tb;
  import ltsm_pkg::*;

  localparam logic [COEF_W-1:0] POS_ZERO = 64'h0000_0000_0000_0000;
  localparam logic [COEF_W-1:0] NEG_ZERO = 64'h8000_0000_0000_0000;
  localparam logic [COEF_W-1:0] POS_INF  = 64'h7FF0_0000_0000_0000;
  localparam logic [COEF_W-1:0] NEG_INF  = 64'hFFF0_0000_0000_0000;
  localparam logic [COEF_W-1:0] SNAN     = 64'h7FF0_0000_0000_0001;
  localparam logic [COEF_W-1:0] QNAN_INV = 64'hFFF8_0000_0000_0000;
  localparam int HOLD_CYCLES = 300;

  // Tracks the open term set and the terms each closed set must produce
  class term_scoreboard;
    bit                rebuild_cfg;
    logic [VAR_W-1:0]  buf_var[MAX_TERMS];
    logic [COEF_W-1:0] buf_coef[MAX_TERMS];
    int                buf_count;
    bit                buf_ovf;
    out_item_t         want_q[$];
    int                errors;
    int                sets_closed;
    int                results_seen;
    int                ovf_sets;
    int                rebuilt_sets;

    function bit is_nan(logic [COEF_W-1:0] c);
      return (&c[62:52]) && (|c[51:0]);
    endfunction

    // Double add with the NaN rules of the block: first NaN operand wins, quieted
    function logic [COEF_W-1:0] fadd(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b);
      if (is_nan(a)) return a | 64'h0008_0000_0000_0000;
      if (is_nan(b)) return b | 64'h0008_0000_0000_0000;
      if (a[62:0] == POS_INF[62:0] && b[62:0] == POS_INF[62:0] && a[63] != b[63])
        return QNAN_INV;
      return $realtobits($bitstoreal(a) + $bitstoreal(b));
    endfunction

    // Buffer one accepted request; close the set on the last flag
    function void note_request(in_item_t it);
      if (buf_count < MAX_TERMS) begin
        buf_var[buf_count]  = it.var_index;
        buf_coef[buf_count] = it.coef_bits;
        buf_count++;
      end else begin
        buf_ovf = 1'b1;
      end
      if (it.last_input) close_set();
    endfunction

    function void close_set();
      logic [VAR_W-1:0]  mvar[MAX_TERMS];
      logic [COEF_W-1:0] mcoef[MAX_TERMS];
      int n, j, kept, cnt;
      bit rebuilt;
      out_item_t r;
      n = 0;
      for (int i = 0; i < buf_count; i++) begin
        if (buf_coef[i][62:0] == 0) continue;
        j = 0;
        while (j < n && mvar[j] < buf_var[i]) j++;
        if (j < n && mvar[j] == buf_var[i]) begin
          mcoef[j] = fadd(mcoef[j], buf_coef[i]);
        end else begin
          for (int k = n; k > j; k--) begin
            mvar[k]  = mvar[k-1];
            mcoef[k] = mcoef[k-1];
          end
          mvar[j]  = buf_var[i];
          mcoef[j] = fadd(POS_ZERO, buf_coef[i]);
          n++;
        end
      end
      // Drop variables whose sum is zero
      kept = 0;
      for (int i = 0; i < n; i++) begin
        if (mcoef[i][62:0] != 0) begin
          mvar[kept]  = mvar[i];
          mcoef[kept] = mcoef[i];
          kept++;
        end
      end
      rebuilt = rebuild_cfg || (n < buf_count);
      cnt = rebuilt ? kept : buf_count;
      if (cnt == 0) begin
        r = '0;
        r.last_output = 1'b1;
        r.none_left   = 1'b1;
        r.was_rebuilt = rebuilt;
        r.overflowed  = buf_ovf;
        want_q = {want_q, r};
      end else begin
        for (int i = 0; i < cnt; i++) begin
          r.out_var       = rebuilt ? mvar[i] : buf_var[i];
          r.out_coef_bits = rebuilt ? mcoef[i] : buf_coef[i];
          r.last_output   = (i + 1 == cnt);
          r.none_left     = 1'b0;
          r.was_rebuilt   = rebuilt;
          r.overflowed    = buf_ovf;
          want_q = {want_q, r};
        end
      end
      sets_closed++;
      if (buf_ovf) ovf_sets++;
      if (rebuilt) rebuilt_sets++;
      buf_count = 0;
      buf_ovf   = 1'b0;
    endfunction

    // Compare one popped result with the oldest expected term
    function void check_result(out_item_t got);
      out_item_t exp_r;
      results_seen++;
      if (want_q.size() == 0) begin
        $error("unexpected result var=%h coef=%h", got.out_var, got.out_coef_bits);
        errors++;
        return;
      end
      exp_r = want_q.pop_front();
      if (got.out_var !== exp_r.out_var) begin
        $error("out_var: expected %h, got %h", exp_r.out_var, got.out_var);
        errors++;
      end
      if (got.out_coef_bits !== exp_r.out_coef_bits) begin
        $error("out_coef_bits: expected %h, got %h", exp_r.out_coef_bits, got.out_coef_bits);
        errors++;
      end
      if (got.last_output !== exp_r.last_output) begin
        $error("last_output: expected %b, got %b", exp_r.last_output, got.last_output);
        errors++;
      end
      if (got.none_left !== exp_r.none_left) begin
        $error("none_left: expected %b, got %b", exp_r.none_left, got.none_left);
        errors++;
      end
      if (got.was_rebuilt !== exp_r.was_rebuilt) begin
        $error("was_rebuilt: expected %b, got %b", exp_r.was_rebuilt, got.was_rebuilt);
        errors++;
      end
      if (got.overflowed !== exp_r.overflowed) begin
        $error("overflowed: expected %b, got %b", exp_r.overflowed, got.overflowed);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item_i = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i = 1'b0;

  term_scoreboard sb = new();
  bit quiet_mode = 1'b0;   // no idling on either side
  bit hold_req   = 1'b0;   // receiver holds off for a long stretch
  int n_requests = 0;

  linear_term_sort_merge dut (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // Send one request; keep push high across back-to-back requests
  task automatic send_term(input logic [VAR_W-1:0] v, input logic [COEF_W-1:0] c,
                           input bit last);
    in_item_t it;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    it.var_index  = v;
    it.coef_bits  = c;
    it.last_input = last;
    push      <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    sb.note_request(it);
    n_requests++;
  endtask

  task automatic stop_sending();
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the sender until every expected term has been popped
  task automatic drain();
    stop_sending();
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_rebuild(input bit b);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= b;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.rebuild_cfg = b;
  endtask

  function automatic logic [COEF_W-1:0] rand_coef();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel < 2) return sel[0] ? NEG_ZERO : POS_ZERO;
    if (sel < 9) return $realtobits(real'($signed($urandom_range(0, 8)) - 4));
    if (sel < 13) return {$urandom, $urandom};
    case (sel)
      13: return POS_INF;
      14: return NEG_INF;
      default: return $urandom_range(0, 1) ? SNAN : {1'b1, 11'h7FF, 1'b1, 51'($urandom)};
    endcase
  endfunction

  function automatic logic [VAR_W-1:0] rand_var(input bit narrow);
    return narrow ? VAR_W'($urandom_range(0, 7)) : VAR_W'($urandom);
  endfunction

  // Send one random set of len terms
  task automatic send_set(input int len, input bit narrow);
    for (int i = 0; i < len; i++)
      send_term(rand_var(narrow), rand_coef(), i == len - 1);
  endtask

  // Pop results with random holds; one long hold-off on request
  initial begin
    int gap;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(result_o);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 9) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("linear_term_sort_merge_tb: errors");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: original order kept, zero skips, zero sums, extremes, specials
    write_rebuild(1'b0);
    send_term(20'hFFFFF, 64'h3FF0_0000_0000_0000, 1'b0);
    send_term(20'h00000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_term(20'h00005, POS_ZERO, 1'b0);
    send_term(20'h00006, NEG_ZERO, 1'b1);
    send_term(20'h00003, 64'h4000_0000_0000_0000, 1'b0);
    send_term(20'h00001, 64'h3FF0_0000_0000_0000, 1'b0);
    send_term(20'h00003, 64'hC000_0000_0000_0000, 1'b1);
    send_term(20'h00009, POS_INF, 1'b0);
    send_term(20'h00009, NEG_INF, 1'b0);
    send_term(20'h00002, SNAN, 1'b0);
    send_term(20'h00002, 64'h4008_0000_0000_0000, 1'b0);
    send_term(20'h00008, 64'h0000_0000_0000_0001, 1'b0);
    send_term(20'h00008, 64'h8000_0000_0000_0001, 1'b1);
    send_term(20'h00004, 64'h3FB9_9999_9999_999A, 1'b0);
    send_term(20'h00004, 64'h3FC9_9999_9999_999A, 1'b1);
    write_rebuild(1'b1);
    send_term(20'hFFFFF, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    send_term(20'h00000, 64'h8000_0000_0000_0001, 1'b1);
    send_term(20'h00007, NEG_ZERO, 1'b1);

    // Overflow while the receiver holds off: the last term is dropped, not its flag
    hold_req = 1'b1;
    for (int i = 0; i < MAX_TERMS; i++)
      send_term(rand_var(1'b0), rand_coef(), 1'b0);
    send_term(20'h00001, 64'h3FF0_0000_0000_0000, 1'b1);
    send_set(5, 1'b1);
    write_rebuild(1'b0);
    send_set(MAX_TERMS + 3, 1'b0);

    // Random sets, mostly short, over both settings
    for (int ph = 0; ph < 4; ph++) begin
      write_rebuild(ph[0]);
      for (int s = 0; s < 8; s++) begin
        if ($urandom_range(0, 9) == 0) send_set($urandom_range(20, MAX_TERMS), 1'b0);
        else send_set($urandom_range(1, 8), $urandom_range(0, 2) != 0);
      end
    end

    // Finish without idling
    write_rebuild(1'b1);
    quiet_mode = 1'b1;
    while (n_requests < 450) send_set($urandom_range(1, 8), $urandom_range(0, 1));
    stop_sending();
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d requests in %0d sets (%0d rebuilt, %0d overflowed), %0d results",
             n_requests, sb.sets_closed, sb.rebuilt_sets, sb.ovf_sets, sb.results_seen);
    if (sb.errors == 0)
      $display("linear_term_sort_merge_tb: clean");
    else
      $display("linear_term_sort_merge_tb: errors");
    $finish;
  end

endmodule
